>>> hdl/retry_queue_scheduler_top_macros.svh
// Assertion macros for the retry queue scheduler checker.
// No dependencies; the including module must provide clk_i and rst_ni.
`ifndef RETRY_QUEUE_SCHEDULER_TOP_MACROS_SVH
`define RETRY_QUEUE_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RQS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rqs_pkg.sv
// Shared types and constants for the retry queue scheduler.
// No dependencies; used by every module of the block.
package rqs_pkg;

  localparam int QUEUE_DEPTH     = 8;
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int IDX_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int TIME_W  = 32;
  localparam int LEN_W   = 16;
  localparam int FLEN_W  = 12;
  localparam int MAC_W   = 48;
  localparam int RCNT_W  = 4;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 32;
  localparam int IVL_W   = 16;
  localparam int PADDR_W = 3;

  localparam logic REG_RETRY_LIMIT    = 1'b0;
  localparam logic REG_RETRY_INTERVAL = 1'b1;

  localparam logic [RCNT_W-1:0] RETRY_LIMIT_RST    = 4'd3;
  localparam logic [IVL_W-1:0]  RETRY_INTERVAL_RST = 16'd100;

  typedef enum logic [1:0] {
    ACT_STORE = 2'd0,
    ACT_RETX  = 2'd1,
    ACT_DROP  = 2'd2,
    ACT_FIN   = 2'd3
  } rqs_action_e;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] rtime;
    logic [RCNT_W-1:0] rcnt;
    logic [FLEN_W-1:0] flen;
    logic [MAC_W-1:0]  mac;
  } rqs_entry_t;

  typedef struct packed {
    logic              en;
    logic              valid;
    logic              upd_sched;
    logic              upd_frame;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] rtime;
    logic [RCNT_W-1:0] rcnt;
    logic [FLEN_W-1:0] flen;
    logic [MAC_W-1:0]  mac;
  } rqs_wr_t;

  typedef struct packed {
    rqs_action_e       action;
    logic [SLOT_W-1:0] slot;
    logic [FLEN_W-1:0] flen;
    logic [MAC_W-1:0]  mac;
    logic [RCNT_W-1:0] rcnt;
    logic              evicted;
    logic [CNT_W-1:0]  relayed;
    logic [CNT_W-1:0]  dropped;
    logic              last;
  } rqs_res_t;

endpackage

>>> hdl/rqs_store.sv
// Entry table of the retry queue scheduler: valid bits plus per-slot descriptors.
// Depends on rqs_pkg.
module rqs_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [rqs_pkg::IDX_W-1:0] rd_idx_i,
  output rqs_pkg::rqs_entry_t       rd_entry_o,
  input  rqs_pkg::rqs_wr_t          wr_i
);
  import rqs_pkg::*;

  logic [QUEUE_DEPTH-1:0] valid_q;
  logic [TIME_W-1:0]      rtime_q [QUEUE_DEPTH];
  logic [RCNT_W-1:0]      rcnt_q  [QUEUE_DEPTH];
  logic [FLEN_W-1:0]      flen_q  [QUEUE_DEPTH];
  logic [MAC_W-1:0]       mac_q   [QUEUE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= wr_i.valid;
    end
  end

  // Descriptor fields are only read behind a set valid bit, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.upd_sched) begin
      rtime_q[wr_i.idx] <= wr_i.rtime;
      rcnt_q[wr_i.idx]  <= wr_i.rcnt;
    end
    if (wr_i.en && wr_i.upd_frame) begin
      flen_q[wr_i.idx] <= wr_i.flen;
      mac_q[wr_i.idx]  <= wr_i.mac;
    end
  end

  always_comb begin
    rd_entry_o.valid = valid_q[rd_idx_i];
    rd_entry_o.rtime = rtime_q[rd_idx_i];
    rd_entry_o.rcnt  = rcnt_q[rd_idx_i];
    rd_entry_o.flen  = flen_q[rd_idx_i];
    rd_entry_o.mac   = mac_q[rd_idx_i];
  end

endmodule

>>> hdl/rqs_seq.sv
// Sequencer of the retry queue scheduler: walks the table one slot per cycle (a due slot
// waits while the result register is full) through a shared time comparator and adder,
// and owns the counters and result register. Depends on rqs_pkg and drives rqs_store.
module rqs_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_kind_i,
  input  logic [rqs_pkg::TIME_W-1:0] in_now_i,
  input  logic [rqs_pkg::LEN_W-1:0]  in_len_i,
  input  logic [rqs_pkg::MAC_W-1:0]  in_mac_i,
  input  logic [rqs_pkg::RCNT_W-1:0] retry_limit_i,
  input  logic [rqs_pkg::IVL_W-1:0]  interval_i,
  output logic [rqs_pkg::IDX_W-1:0]  rd_idx_o,
  input  rqs_pkg::rqs_entry_t        rd_entry_i,
  output rqs_pkg::rqs_wr_t           wr_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output rqs_pkg::rqs_res_t          res_o
);
  import rqs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_SCAN,
    ST_ENQ_WR,
    ST_SVC_SCAN,
    ST_SVC_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [FLEN_W-1:0] len_q, len_d;
  logic [MAC_W-1:0]  mac_q, mac_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  free_q, free_d;
  logic [TIME_W-1:0] best_q, best_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [CNT_W-1:0]  relayed_q, relayed_d;
  logic [CNT_W-1:0]  dropped_q, dropped_d;
  logic              out_valid_q, out_valid_d;
  rqs_res_t          out_q, out_d;

  logic [TIME_W-1:0] cmp_a, cmp_b;
  logic              cmp_lt;
  logic [TIME_W-1:0] sched_time;
  logic              out_free;
  logic              last_idx;
  logic              due;
  logic [IDX_W-1:0]  enq_slot;

  // Shared unit: one 32-bit magnitude compare and the reschedule adder.
  always_comb begin
    if (state_q == ST_SVC_SCAN) begin
      cmp_a = now_q;
      cmp_b = rd_entry_i.rtime;
    end else begin
      cmp_a = rd_entry_i.rtime;
      cmp_b = best_q;
    end
    cmp_lt     = cmp_a < cmp_b;
    sched_time = now_q + TIME_W'(interval_i);
  end

  assign out_free   = !out_valid_q || res_ready_i;
  assign last_idx   = (idx_q == IDX_W'(QUEUE_DEPTH - 1));
  assign due        = rd_entry_i.valid && !cmp_lt;
  assign enq_slot   = found_q ? free_q : best_idx_q;
  assign in_ready_o = (state_q == ST_IDLE);
  assign rd_idx_o   = idx_q;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    now_d       = now_q;
    len_d       = len_q;
    mac_d       = mac_q;
    found_d     = found_q;
    free_d      = free_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    relayed_d   = relayed_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    wr_o        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          now_d   = in_now_i;
          len_d   = (in_len_i > LEN_W'(MAX_FRAME_BYTES)) ? FLEN_W'(MAX_FRAME_BYTES)
                                                         : FLEN_W'(in_len_i);
          mac_d   = in_mac_i;
          idx_d   = '0;
          found_d = 1'b0;
          state_d = in_kind_i ? ST_SVC_SCAN : ST_ENQ_SCAN;
        end
      end

      ST_ENQ_SCAN: begin
        if (!found_q && !rd_entry_i.valid) begin
          found_d = 1'b1;
          free_d  = idx_q;
        end
        // Strict less-than keeps the lowest index among equal retry times.
        if (idx_q == '0 || cmp_lt) begin
          best_d     = rd_entry_i.rtime;
          best_idx_d = idx_q;
        end
        if (last_idx) begin
          state_d = ST_ENQ_WR;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      ST_ENQ_WR: begin
        if (out_free) begin
          dropped_d      = dropped_q + CNT_W'(!found_q);
          wr_o.en        = 1'b1;
          wr_o.valid     = 1'b1;
          wr_o.upd_sched = 1'b1;
          wr_o.upd_frame = 1'b1;
          wr_o.idx       = enq_slot;
          wr_o.rtime     = sched_time;
          wr_o.rcnt      = '0;
          wr_o.flen      = len_q;
          wr_o.mac       = mac_q;
          out_valid_d    = 1'b1;
          out_d.action   = ACT_STORE;
          out_d.slot     = SLOT_W'(enq_slot);
          out_d.flen     = len_q;
          out_d.mac      = mac_q;
          out_d.rcnt     = '0;
          out_d.evicted  = !found_q;
          out_d.relayed  = relayed_q;
          out_d.dropped  = dropped_d;
          out_d.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      ST_SVC_SCAN: begin
        // A due slot waits here until the result register can take its item.
        if (!due || out_free) begin
          if (due) begin
            wr_o.en       = 1'b1;
            wr_o.idx      = idx_q;
            out_valid_d   = 1'b1;
            out_d.slot    = SLOT_W'(idx_q);
            out_d.flen    = rd_entry_i.flen;
            out_d.mac     = rd_entry_i.mac;
            out_d.evicted = 1'b0;
            out_d.last    = 1'b0;
            if (rd_entry_i.rcnt >= retry_limit_i) begin
              wr_o.valid   = 1'b0;
              dropped_d    = dropped_q + CNT_W'(1);
              out_d.action = ACT_DROP;
              out_d.rcnt   = rd_entry_i.rcnt;
            end else begin
              wr_o.valid     = 1'b1;
              wr_o.upd_sched = 1'b1;
              wr_o.rtime     = sched_time;
              wr_o.rcnt      = rd_entry_i.rcnt + RCNT_W'(1);
              relayed_d      = relayed_q + CNT_W'(1);
              out_d.action   = ACT_RETX;
              out_d.rcnt     = wr_o.rcnt;
            end
            out_d.relayed = relayed_d;
            out_d.dropped = dropped_d;
          end
          if (last_idx) begin
            state_d = ST_SVC_FIN;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end

      ST_SVC_FIN: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.action  = ACT_FIN;
          out_d.slot    = '0;
          out_d.flen    = '0;
          out_d.mac     = '0;
          out_d.rcnt    = '0;
          out_d.evicted = 1'b0;
          out_d.relayed = relayed_q;
          out_d.dropped = dropped_q;
          out_d.last    = 1'b1;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      found_q     <= 1'b0;
      relayed_q   <= '0;
      dropped_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      relayed_q   <= relayed_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    len_q      <= len_d;
    mac_q      <= mac_d;
    free_q     <= free_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    out_q      <= out_d;
  end

endmodule

>>> hdl/retry_queue_scheduler_top.sv
// Retry queue scheduler: a table of pending retransmissions with timed service.
// Input channel s_axis: one item per command. tuser carries the kind (0 enqueue,
// 1 service); tdata carries now_tick, length and dest_mac.
// Output channel m_axis: result items. tuser carries the action (stored,
// retransmit, dropped, service finished); tlast marks the final result of a command.
// Configuration goes through the APB port: the retry limit at 0x0, retry_interval at 0x4.
// Every command walks all table slots, one slot per cycle while the output is not
// stalled, through a single shared time comparator. An enqueue yields its one
// result once the scan is done; a service yields one result per due slot as the
// scan passes it, then a closing result with both running counters.
// The result sits in a single output register, so the next command is accepted
// while the last result still waits. If the receiver stalls, the scan holds at
// the next slot that has a result to report.
// Reset clears all valid bits, both counters and the handshake state, and loads
// a retry limit of 3 and retry_interval 100.
// Depends on rqs_pkg, rqs_store and rqs_seq.
module retry_queue_scheduler_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [95:0]                  s_axis_tdata,  // now_tick, length, dest_mac
  input  logic                         s_axis_tuser,  // kind
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // slot, frame_length, dest_mac, retry_count, evicted, relayed_total,
  // dropped_total, zero pad
  output logic [135:0]                 m_axis_tdata,
  output logic [1:0]                   m_axis_tuser,  // action
  output logic                         m_axis_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rqs_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rqs_pkg::*;

  logic [RCNT_W-1:0] retry_limit_q;
  logic [IVL_W-1:0]  interval_q;
  logic              cfg_wr;
  logic [IDX_W-1:0]  rd_idx;
  rqs_entry_t        rd_entry;
  rqs_wr_t           wr;
  rqs_res_t          res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RETRY_LIMIT_RST;
      interval_q    <= RETRY_INTERVAL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RETRY_LIMIT:    retry_limit_q <= pwdata[RCNT_W-1:0];
        REG_RETRY_INTERVAL: interval_q    <= pwdata[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RETRY_LIMIT:    prdata = 32'(retry_limit_q);
      REG_RETRY_INTERVAL: prdata = 32'(interval_q);
      default:            prdata = '0;
    endcase
  end

  rqs_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry),
    .wr_i       (wr)
  );

  rqs_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_kind_i     (s_axis_tuser),
    .in_now_i      (s_axis_tdata[31:0]),
    .in_len_i      (s_axis_tdata[47:32]),
    .in_mac_i      (s_axis_tdata[95:48]),
    .retry_limit_i (retry_limit_q),
    .interval_i    (interval_q),
    .rd_idx_o      (rd_idx),
    .rd_entry_i    (rd_entry),
    .wr_o          (wr),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tuser = res.action;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {1'b0, res.dropped, res.relayed, res.evicted, res.rcnt,
                         res.mac, res.flen, res.slot};

endmodule

>>> hdl/rqs_checker.sv
// Port-level checker for the retry queue scheduler, bound to the top level.
// Depends on rqs_pkg and retry_queue_scheduler_top_macros.svh.
`include "retry_queue_scheduler_top_macros.svh"

module rqs_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  import rqs_pkg::*;

  // A command keeps the block busy for at least the following cycle.
  `RQS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while a command was still running")

  // Stored and finished results close their command; per-slot service results never do.
  `RQS_ASSERT_NOW(a_last_on_close, m_axis_tvalid && (m_axis_tuser == ACT_STORE || m_axis_tuser == ACT_FIN), m_axis_tlast, "closing result without tlast")
  `RQS_ASSERT_NOW(a_no_last_mid, m_axis_tvalid && (m_axis_tuser == ACT_RETX || m_axis_tuser == ACT_DROP), !m_axis_tlast, "per-slot service result marked last")

  // The finished result carries only the counters.
  `RQS_ASSERT_NOW(a_fin_fields_zero, m_axis_tvalid && m_axis_tuser == ACT_FIN, m_axis_tdata[70:0] == '0, "finished result with nonzero slot fields")

  `RQS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or vanished")

endmodule

bind retry_queue_scheduler_top rqs_checker u_rqs_checker (.*);

>>> tb/retry_table_model_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the retry queue scheduler: a cycle-free predictor of the slot table
// and the queue of result items it expects. Depends on rqs_pkg only.
package retry_table_model_pkg;
  import rqs_pkg::*;

  class retry_table_model;
    bit                live[QUEUE_DEPTH];
    logic [TIME_W-1:0] due_at[QUEUE_DEPTH];
    logic [RCNT_W-1:0] tries[QUEUE_DEPTH];
    logic [FLEN_W-1:0] flen[QUEUE_DEPTH];
    logic [MAC_W-1:0]  mac[QUEUE_DEPTH];
    logic [CNT_W-1:0]  relayed;
    logic [CNT_W-1:0]  dropped;
    logic [RCNT_W-1:0] retry_limit;
    logic [IVL_W-1:0]  interval;
    rqs_res_t          pending_results[$];

    function new();
      foreach (live[i]) live[i] = 1'b0;
      relayed     = '0;
      dropped     = '0;
      retry_limit = RETRY_LIMIT_RST;
      interval    = RETRY_INTERVAL_RST;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Counters are sampled after the update that caused this result item.
    function void push_result(rqs_action_e act, int slot, logic [FLEN_W-1:0] fl,
                              logic [MAC_W-1:0] m, logic [RCNT_W-1:0] rc, bit ev, bit lst);
      rqs_res_t r;
      r.action  = act;
      r.slot    = SLOT_W'(slot);
      r.flen    = fl;
      r.mac     = m;
      r.rcnt    = rc;
      r.evicted = ev;
      r.relayed = relayed;
      r.dropped = dropped;
      r.last    = lst;
      pending_results.push_back(r);
    endfunction

    function void note_command(bit kind, logic [TIME_W-1:0] now, logic [LEN_W-1:0] len,
                               logic [MAC_W-1:0] dmac);
      int                slot;
      bit                evicted;
      logic [TIME_W-1:0] earliest;
      logic [LEN_W-1:0]  clamped;
      if (!kind) begin
        slot    = -1;
        evicted = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (!live[i] && slot < 0) slot = i;
        if (slot < 0) begin
          // Table full: the entry due first goes, lowest index on a tie.
          slot     = 0;
          earliest = due_at[0];
          for (int i = 1; i < QUEUE_DEPTH; i++)
            if (due_at[i] < earliest) begin
              earliest = due_at[i];
              slot     = i;
            end
          evicted = 1'b1;
          dropped++;
        end
        clamped      = (len > MAX_FRAME_BYTES) ? LEN_W'(MAX_FRAME_BYTES) : len;
        flen[slot]   = clamped[FLEN_W-1:0];
        mac[slot]    = dmac;
        tries[slot]  = '0;
        due_at[slot] = now + TIME_W'(interval);
        live[slot]   = 1'b1;
        push_result(ACT_STORE, slot, flen[slot], dmac, '0, evicted, 1'b1);
      end else begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (live[i] && now >= due_at[i]) begin
            if (tries[i] >= retry_limit) begin
              live[i] = 1'b0;
              dropped++;
              push_result(ACT_DROP, i, flen[i], mac[i], tries[i], 1'b0, 1'b0);
            end else begin
              tries[i]++;
              due_at[i] = now + TIME_W'(interval);
              relayed++;
              push_result(ACT_RETX, i, flen[i], mac[i], tries[i], 1'b0, 1'b0);
            end
          end
        end
        push_result(ACT_FIN, 0, '0, '0, '0, 1'b0, 1'b1);
      end
    endfunction

    // Returns an empty string on a match, else one line naming the bad fields.
    function string check_result(rqs_res_t got);
      rqs_res_t want;
      string    diff;
      diff = "";
      if (pending_results.size() == 0) begin
        diff = $sformatf("unexpected result item: action %0d slot %0d", got.action, got.slot);
      end else begin
        want = pending_results.pop_front();
        if (got.action !== want.action)
          diff = {diff, $sformatf(" action %0d/%0d", got.action, want.action)};
        if (got.slot !== want.slot)
          diff = {diff, $sformatf(" slot %0d/%0d", got.slot, want.slot)};
        if (got.flen !== want.flen)
          diff = {diff, $sformatf(" frame_length %0d/%0d", got.flen, want.flen)};
        if (got.mac !== want.mac)
          diff = {diff, $sformatf(" dest_mac %h/%h", got.mac, want.mac)};
        if (got.rcnt !== want.rcnt)
          diff = {diff, $sformatf(" retry_count %0d/%0d", got.rcnt, want.rcnt)};
        if (got.evicted !== want.evicted)
          diff = {diff, $sformatf(" evicted %b/%b", got.evicted, want.evicted)};
        if (got.relayed !== want.relayed)
          diff = {diff, $sformatf(" relayed_total %0d/%0d", got.relayed, want.relayed)};
        if (got.dropped !== want.dropped)
          diff = {diff, $sformatf(" dropped_total %0d/%0d", got.dropped, want.dropped)};
        if (got.last !== want.last)
          diff = {diff, $sformatf(" last %b/%b", got.last, want.last)};
        if (diff != "") diff = {"result item got/expected:", diff};
      end
      return diff;
    endfunction
  endclass

endpackage

>>> tb/retry_queue_scheduler_top_test.sv
`timescale 1ns / 100ps
// Self-checking test of retry_queue_scheduler_top: directed and random enqueue and
// service items against the retry_table_model scoreboard, with random back-pressure.
// Depends on rqs_pkg, retry_table_model_pkg and retry_queue_scheduler_top.
module retry_queue_scheduler_top_test;
  import rqs_pkg::*;
  import retry_table_model_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 40;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [95:0]          s_axis_tdata;   // now_tick, length, dest_mac
  logic                 s_axis_tuser;   // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // slot, frame_length, dest_mac, retry_count, evicted, relayed_total,
  // dropped_total, zero pad
  logic [135:0]         m_axis_tdata;
  logic [1:0]           m_axis_tuser;   // action
  logic                 m_axis_tlast;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  retry_table_model table_model;
  int                errors;
  bit                quiet;
  bit                hold_req;
  logic [31:0]       wall_tick;

  retry_queue_scheduler_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_command(bit kind, logic [31:0] now, logic [15:0] len,
                              logic [47:0] dmac);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {dmac, len, now};
    do @(posedge clk_i); while (!s_axis_tready);
    table_model.note_command(kind, now, len, dmac);
  endtask

  task automatic apb_access(bit wr, logic idx, logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Every item yields at least one result, so an empty queue means the scan is done;
  // the extra cycles cover the last result leaving the output register.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (table_model.outstanding() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_registers(logic [3:0] limit, logic [15:0] ivl);
    logic [31:0] rd;
    settle_block();
    apb_access(1'b1, REG_RETRY_LIMIT, {28'd0, limit}, rd);
    apb_access(1'b1, REG_RETRY_INTERVAL, {16'd0, ivl}, rd);
    table_model.retry_limit = limit;
    table_model.interval    = ivl;
    apb_access(1'b0, REG_RETRY_LIMIT, '0, rd);
    if (rd[3:0] !== limit) report($sformatf("retry limit reads %h, wrote %h", rd, limit));
    apb_access(1'b0, REG_RETRY_INTERVAL, '0, rd);
    if (rd[15:0] !== ivl) report($sformatf("retry_interval reads %h, wrote %h", rd, ivl));
  endtask

  // Coherent traffic on an advancing clock, with a little noise on the tick.
  task automatic run_phase(int count);
    bit          kind;
    logic [31:0] now;
    logic [15:0] len;
    for (int i = 0; i < count; i++) begin
      kind      = $urandom_range(0, 99) < 45;
      wall_tick = wall_tick + $urandom_range(0, int'(table_model.interval) / 2 + 2);
      now       = ($urandom_range(0, 15) == 0) ? $urandom : wall_tick;
      len       = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2200));
      send_command(kind, now, len, {16'($urandom), $urandom});
    end
  endtask

  initial begin : result_monitor
    rqs_res_t got;
    string    msg;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.action  = rqs_action_e'(m_axis_tuser);
        got.slot    = m_axis_tdata[5:0];
        got.flen    = m_axis_tdata[17:6];
        got.mac     = m_axis_tdata[65:18];
        got.rcnt    = m_axis_tdata[69:66];
        got.evicted = m_axis_tdata[70];
        got.relayed = m_axis_tdata[102:71];
        got.dropped = m_axis_tdata[134:103];
        got.last    = m_axis_tlast;
        msg = table_model.check_result(got);
        if (msg != "") report(msg);
      end
    end
  end

  initial begin : output_pacer
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // Long hold-off so the output register and the input side both back up.
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        idle = 0;
      else
        idle++;
      if (idle >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [3:0]  limit;
    logic [15:0] ivl;
    table_model   = new();
    errors        = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    wall_tick     = '0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the table under the reset settings; the first entry's due time wraps.
    send_command(1'b0, 32'hFFFF_FFF0, 16'd0, 48'd0);
    send_command(1'b0, 32'd0, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    send_command(1'b0, 32'd0, 16'd2048, {16'($urandom), $urandom});
    send_command(1'b0, 32'd0, 16'd2049, {16'($urandom), $urandom});
    send_command(1'b0, 32'd0, 16'd2047, {16'($urandom), $urandom});
    send_command(1'b0, 32'd0, 16'd64, {16'($urandom), $urandom});
    send_command(1'b0, 32'd0, 16'd1500, {16'($urandom), $urandom});
    send_command(1'b0, 32'd0, 16'd1, {16'($urandom), $urandom});
    // Full table: first eviction takes the earliest entry, the second a tie.
    send_command(1'b0, 32'd50, 16'd100, {16'($urandom), $urandom});
    send_command(1'b0, 32'd50, 16'd200, {16'($urandom), $urandom});
    // Nothing due, then every slot due three times over, then all expire.
    send_command(1'b1, 32'd0, '0, '0);
    send_command(1'b1, 32'hFFFF_FFFF, '0, '0);
    send_command(1'b1, 32'd99, '0, '0);
    send_command(1'b1, 32'd300, '0, '0);
    send_command(1'b1, 32'd400, '0, '0);

    // With no retries allowed a due entry is dropped at once.
    set_registers(4'd0, 16'd0);
    send_command(1'b0, 32'd1000, 16'd77, {16'($urandom), $urandom});
    send_command(1'b0, 32'd1000, 16'd78, {16'($urandom), $urandom});
    send_command(1'b1, 32'd1000, '0, '0);

    // Lowering the limit after two retries drops the entry at the next service.
    set_registers(4'd15, 16'd0);
    send_command(1'b0, 32'd2000, 16'd300, {16'($urandom), $urandom});
    send_command(1'b1, 32'd2000, '0, '0);
    send_command(1'b1, 32'd2000, '0, '0);
    set_registers(4'd1, 16'd0);
    send_command(1'b1, 32'd2001, '0, '0);

    wall_tick = 32'd3000;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin limit = 4'd15; ivl = 16'hFFFF; end
        1: begin limit = 4'd0;  ivl = 16'd0;    end
        2: begin limit = 4'd1;  ivl = 16'd1;    end
        3: begin limit = 4'd3;  ivl = 16'd100;  end
        6: begin limit = 4'd15; ivl = 16'd5;    end
        7: begin limit = 4'd2;  ivl = 16'd30;   end
        default: begin
          limit = 4'($urandom_range(0, 15));
          ivl   = 16'($urandom_range(0, 400));
        end
      endcase
      set_registers(limit, ivl);
      quiet = (p == 2);
      if (p == 3) wall_tick = 32'hFFFF_F800;
      if (p == 5) hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
    end
    quiet = 1'b0;

    settle_block();
    repeat (20) @(posedge clk_i);
    if (table_model.outstanding() != 0)
      report($sformatf("%0d result items never arrived", table_model.outstanding()));
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
